/* rtl/bba_pkg.sv */
// Shared types and constants of the bitmap block allocator.
// Holds the request kinds, the result status codes, the bitmap and summary word constants and the item field widths.
// No dependencies.
package bba_pkg;

   // Request kinds as carried in req_tuser.
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Result status of one item.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // One summary word carries the full flags of this many bitmap bytes.
   localparam int SUMMARY_BITS  = 32;
   localparam int SUMMARY_SHIFT = 5;

   // Bitmap byte values.
   localparam logic [7:0] BYTE_FULL  = 8'hFF;
   localparam logic [7:0] BYTE_RESET = 8'h07;

   // Field widths of the item channels.
   localparam int BLOCK_IN_W  = 14;
   localparam int BLOCK_OUT_W = 13;

endpackage

/* rtl/bba_ram.sv */
// Simple dual-port synchronous RAM with one write and one registered read port.
// Used for the bitmap store and for the full-flag summary store.
// No dependencies.
module bba_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* rtl/bba_encoder.sv */
// Priority encoder that finds the lowest clear bit of a vector.
// Serves the word summary, the byte summary and the bitmap byte search.
// No dependencies.
module bba_encoder #(
   parameter int WIDTH = 32
) (
   input  logic [WIDTH-1:0]                            bits,
   output logic                                        found,
   output logic [((WIDTH > 1) ? $clog2(WIDTH) : 1)-1:0] index
);

   localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   // Scan from the top so that the lowest clear bit wins.
   always_comb begin
      found = ~(&bits);
      index = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (!bits[i]) begin
            index = IW'(i);
         end
      end
   end

endmodule

/* rtl/bitmap_block_allocator_core.sv */
// Top level of the bitmap block allocator: sequencer, summary vector and
// the two stores. Depends on bba_pkg, bba_ram and bba_encoder.
//
//   Channel  Direction  Ports            Payload
//   req      in         req_t*           tuser: kind; tdata: block_number
//   rsp      out        rsp_t*           tuser: status; tdata: granted_block
//
// An allocate runs in steps from acceptance: the word summary picks a summary
// word, the summary RAM read picks a byte, the bitmap RAM read picks the bit
// and both stores are written back, then the result register loads. A free
// reads and writes back the byte and its summary word; a full or out-of-range
// item loads its result directly. After reset a clearing pass writes one bitmap
// byte per cycle, BYTES_PER_LAYER * LAYERS bytes (1024 by default), before the
// first item. A result that is not taken holds the next item in its last state.
module bitmap_block_allocator_core
   import bba_pkg::*;
#(
   parameter int BYTES_PER_LAYER = 512,
   parameter int LAYERS          = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [13:0] block_number, [15:14] zero
   input  logic [0:0]  req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [12:0] granted_block, [15:13] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int N_BYTES      = BYTES_PER_LAYER * LAYERS;
   localparam int TOTAL_BLOCKS = N_BYTES * 8;
   localparam int BYTE_AW      = (N_BYTES > 1) ? $clog2(N_BYTES) : 1;
   localparam int SUM_WORDS    = (N_BYTES + SUMMARY_BITS - 1) / SUMMARY_BITS;
   localparam int SW_AW        = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
   localparam int WA           = SW_AW + SUMMARY_SHIFT;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SUM,
      S_ABYTE,
      S_FBYTE,
      S_DONE
   } state_type;

   state_type                     state_ff, state_in;
   logic [BYTE_AW-1:0]            clr_ff, clr_in;
   logic [SUM_WORDS-1:0]          top_ff, top_in;
   logic [WA-1:0]                 byte_ff, byte_in;
   logic [2:0]                    bit_ff, bit_in;
   logic [SUMMARY_BITS-1:0]       sumw_ff, sumw_in;
   status_type                    res_status_ff, res_status_in;
   logic [BLOCK_OUT_W-1:0]        res_block_ff, res_block_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   status_type                    rsp_status_ff, rsp_status_in;
   logic [BLOCK_OUT_W-1:0]        rsp_block_ff, rsp_block_in;

   // Memory port controls.
   logic                          bm_we, bm_re;
   logic [BYTE_AW-1:0]            bm_waddr, bm_raddr;
   logic [7:0]                    bm_wdata, bm_rdata;
   logic                          sm_we, sm_re;
   logic [SW_AW-1:0]              sm_waddr, sm_raddr;
   logic [SUMMARY_BITS-1:0]       sm_wdata, sm_rdata;

   // Encoder results.
   logic                          top_found, sum_found, bit_found;
   logic [SW_AW-1:0]              top_idx;
   logic [SUMMARY_SHIFT-1:0]      sum_idx;
   logic [2:0]                    bit_idx;

   // Request decode.
   logic                          req_accept;
   logic                          req_kind;
   logic [BLOCK_IN_W-1:0]         req_block;
   logic                          req_in_range;
   logic [WA-1:0]                 req_byte;

   // Read-modify-write values.
   logic [7:0]                    new_byte;
   logic [SUMMARY_BITS-1:0]       new_sum;
   logic [SUMMARY_BITS-1:0]       clr_pad;
   logic [SW_AW-1:0]              cur_word;
   logic [SUMMARY_SHIFT-1:0]      cur_slot;
   logic                          rsp_load;

   bba_ram #(.DEPTH(N_BYTES), .WIDTH(8)) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (bm_wdata),
      .rd_en   (bm_re),
      .rd_addr (bm_raddr),
      .rd_data (bm_rdata)
   );

   bba_ram #(.DEPTH(SUM_WORDS), .WIDTH(SUMMARY_BITS)) u_summary_ram (
      .clock   (clock),
      .wr_en   (sm_we),
      .wr_addr (sm_waddr),
      .wr_data (sm_wdata),
      .rd_en   (sm_re),
      .rd_addr (sm_raddr),
      .rd_data (sm_rdata)
   );

   bba_encoder #(.WIDTH(SUM_WORDS)) u_top_enc (
      .bits  (top_ff),
      .found (top_found),
      .index (top_idx)
   );

   bba_encoder #(.WIDTH(SUMMARY_BITS)) u_sum_enc (
      .bits  (sm_rdata),
      .found (sum_found),
      .index (sum_idx)
   );

   bba_encoder #(.WIDTH(8)) u_bit_enc (
      .bits  (bm_rdata),
      .found (bit_found),
      .index (bit_idx)
   );

   // Handshake and request fields.
   assign req_tready   = (state_ff == S_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign req_kind     = req_tuser[0];
   assign req_block    = req_tdata[BLOCK_IN_W-1:0];
   assign req_in_range = (32'(req_block) < TOTAL_BLOCKS);
   assign req_byte     = WA'(req_block >> 3);

   assign cur_word = byte_ff[WA-1:SUMMARY_SHIFT];
   assign cur_slot = byte_ff[SUMMARY_SHIFT-1:0];
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // Summary bits of bytes past the end of the store start out as full.
   always_comb begin
      for (int b = 0; b < SUMMARY_BITS; b++) begin
         clr_pad[b] = (((32'(clr_ff) << SUMMARY_SHIFT) + 32'(b)) >= N_BYTES);
      end
   end

   // Sequencer: next state, memory accesses and results.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      top_in        = top_ff;
      byte_in       = byte_ff;
      bit_in        = bit_ff;
      sumw_in       = sumw_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;

      bm_we    = 1'b0;
      bm_waddr = byte_ff[BYTE_AW-1:0];
      bm_wdata = '0;
      bm_re    = 1'b0;
      bm_raddr = byte_ff[BYTE_AW-1:0];
      sm_we    = 1'b0;
      sm_waddr = cur_word;
      sm_wdata = '0;
      sm_re    = 1'b0;
      sm_raddr = cur_word;
      new_byte = '0;
      new_sum  = '0;

      unique case (state_ff)
         S_CLEAR: begin
            bm_we    = 1'b1;
            bm_waddr = clr_ff;
            bm_wdata = (clr_ff == '0) ? BYTE_RESET : '0;
            sm_we    = (32'(clr_ff) < SUM_WORDS);
            sm_waddr = SW_AW'(clr_ff);
            sm_wdata = clr_pad;
            if (clr_ff == BYTE_AW'(N_BYTES - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_accept) begin
               if (req_kind == KIND_ALLOC) begin
                  // Allocate: read the first summary word that has room.
                  if (top_found) begin
                     sm_re    = 1'b1;
                     sm_raddr = top_idx;
                     byte_in  = {top_idx, {SUMMARY_SHIFT{1'b0}}};
                     state_in = S_SUM;
                  end else begin
                     res_status_in = STATUS_FULL;
                     res_block_in  = '0;
                     state_in      = S_DONE;
                  end
               end else if (req_in_range) begin
                  // Free: read the byte and its summary word.
                  bm_re    = 1'b1;
                  bm_raddr = req_byte[BYTE_AW-1:0];
                  sm_re    = 1'b1;
                  sm_raddr = req_byte[WA-1:SUMMARY_SHIFT];
                  byte_in  = req_byte;
                  bit_in   = req_block[2:0];
                  state_in = S_FBYTE;
               end else begin
                  res_status_in = STATUS_RANGE;
                  res_block_in  = '0;
                  state_in      = S_DONE;
               end
            end
         end

         S_SUM: begin
            // Pick the lowest byte that is not full and read it.
            sumw_in = sm_rdata;
            if (sum_found) begin
               byte_in  = {cur_word, sum_idx};
               bm_re    = 1'b1;
               bm_raddr = BYTE_AW'({cur_word, sum_idx});
               state_in = S_ABYTE;
            end else begin
               res_status_in = STATUS_FULL;
               res_block_in  = '0;
               state_in      = S_DONE;
            end
         end

         S_ABYTE: begin
            // Set the lowest clear bit and update both summary levels.
            if (bit_found) begin
               new_byte = bm_rdata | (8'd1 << bit_idx);
               new_sum  = sumw_ff
                        | (SUMMARY_BITS'(new_byte == BYTE_FULL) << cur_slot);
               bm_we    = 1'b1;
               bm_wdata = new_byte;
               sm_we    = 1'b1;
               sm_wdata = new_sum;
               if (&new_sum) begin
                  top_in[cur_word] = 1'b1;
               end
               res_status_in = STATUS_OK;
               res_block_in  = BLOCK_OUT_W'({byte_ff, bit_idx});
            end else begin
               res_status_in = STATUS_FULL;
               res_block_in  = '0;
            end
            state_in = S_DONE;
         end

         S_FBYTE: begin
            // Clear the bit; the byte and its word now have room.
            new_byte = bm_rdata & ~(8'd1 << bit_ff);
            new_sum  = sm_rdata & ~(SUMMARY_BITS'(1) << cur_slot);
            bm_we    = 1'b1;
            bm_wdata = new_byte;
            sm_we    = 1'b1;
            sm_wdata = new_sum;
            top_in[cur_word] = 1'b0;
            res_status_in    = STATUS_OK;
            res_block_in     = '0;
            state_in         = S_DONE;
         end

         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_block_in  = res_block_ff;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff       <= byte_in;
      bit_ff        <= bit_in;
      sumw_ff       <= sumw_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(16 - BLOCK_OUT_W){1'b0}}, rsp_block_ff};

endmodule
